>>> src/assert_macros.svh
// assertion macros shared by the find-and-replace rtl
// no dependencies; assertions compile out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> src/spr_pkg.sv
// types, register codes and byte helpers for the find-and-replace block
// no dependencies
`timescale 1ns / 1ps

package spr_pkg;

    localparam int MAX_BYTES = 8;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PAT_BYTES = 3'd0;
    localparam t_cfg_idx REG_PAT_LEN   = 3'd1;
    localparam t_cfg_idx REG_REP_BYTES = 3'd2;
    localparam t_cfg_idx REG_REP_LEN   = 3'd3;
    localparam t_cfg_idx REG_IGN_CASE  = 3'd4;

    // one queued job: emit n bytes of data, or a bare end marker when n is zero
    typedef struct packed {
        logic [MAX_BYTES*8-1:0] data;
        logic [3:0]             n;
        logic                   last;
        logic                   any_rep;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
        logic       any_replaced;
    } t_word;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> src/spr_fifo.sv
// small synchronous fifo used for the job queue and the result queue
// no dependencies
`timescale 1ns / 1ps

module spr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> src/spr_front.sv
// front end: config registers, pending window, pattern compare, job build
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_front
    import spr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  t_cfg_idx               i_cfg_index,
    input  logic [MAX_BYTES*8-1:0] i_cfg_data,
    input  logic                   i_accept,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output logic                   o_cmd_push,
    output t_cmd                   o_cmd
);

    localparam int WIN_W = PATTERN_MAX * 8;
    localparam int CNT_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [MAX_BYTES*8-1:0] r_pat;
    logic [3:0]             r_pat_len;
    logic [MAX_BYTES*8-1:0] r_rep;
    logic [3:0]             r_rep_len;
    logic                   r_ign_case;

    logic [WIN_W-1:0]       r_win, n_win;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_seen, n_seen;

    logic [3:0]             len_eff, rep_eff, cnt_p1;
    logic [WIN_W-1:0]       w_app;
    logic                   full_win, cmp_ok, match;

    always_comb begin
        if (r_pat_len == 4'd0) begin
            len_eff = 4'd1;
        end else if (r_pat_len > 4'(PATTERN_MAX)) begin
            len_eff = 4'(PATTERN_MAX);
        end else begin
            len_eff = r_pat_len;
        end
        rep_eff = (r_rep_len > 4'(REPLACE_MAX)) ? 4'(REPLACE_MAX) : r_rep_len;
    end

    // append the new word at the fill point
    always_comb begin
        w_app = r_win;
        w_app[r_cnt*8 +: 8] = i_byte;
    end

    assign cnt_p1   = 4'(r_cnt) + 4'd1;
    assign full_win = (cnt_p1 == len_eff);

    always_comb begin
        cmp_ok = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (4'(i) < len_eff &&
                fold(w_app[i*8 +: 8], r_ign_case) != fold(r_pat[i*8 +: 8], r_ign_case)) begin
                cmp_ok = 1'b0;
            end
        end
    end

    assign match = full_win && cmp_ok;

    always_comb begin
        o_cmd.data    = match ? r_rep : (MAX_BYTES*8)'(w_app);
        o_cmd.last    = i_last;
        o_cmd.any_rep = r_seen || match;
        priority if (match) begin
            o_cmd.n = rep_eff;
        end else if (i_last) begin
            o_cmd.n = cnt_p1;
        end else if (full_win) begin
            o_cmd.n = 4'd1;
        end else begin
            o_cmd.n = 4'd0;
        end
    end

    assign o_cmd_push = i_accept && (o_cmd.n != 4'd0 || i_last);

    always_comb begin
        n_win  = r_win;
        n_cnt  = r_cnt;
        n_seen = r_seen;
        if (i_cfg_wr_en && i_cfg_index == REG_PAT_LEN) begin
            n_cnt = '0;
        end
        if (i_accept) begin
            n_seen = i_last ? 1'b0 : (r_seen || match);
            priority if (match || i_last) begin
                n_cnt = '0;
            end else if (full_win) begin
                // oldest word leaves, fill point stays at length minus one
                n_win = w_app >> 8;
            end else begin
                n_win = w_app;
                n_cnt = CNT_W'(cnt_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat      <= '0;
            r_pat_len  <= 4'd1;
            r_rep      <= '0;
            r_rep_len  <= 4'd0;
            r_ign_case <= 1'b0;
            r_cnt      <= '0;
            r_seen     <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_seen <= n_seen;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_PAT_BYTES: r_pat      <= i_cfg_data;
                    REG_PAT_LEN:   r_pat_len  <= i_cfg_data[3:0];
                    REG_REP_BYTES: r_rep      <= i_cfg_data;
                    REG_REP_LEN:   r_rep_len  <= i_cfg_data[3:0];
                    REG_IGN_CASE:  r_ign_case <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

>>> src/spr_back.sv
// back end: expands one queued job into result words, one per cycle while the result queue is not full
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_back
    import spr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cmd_empty,
    input  t_cmd  i_cmd,
    output logic  o_cmd_pop,
    input  logic  i_out_full,
    output logic  o_word_push,
    output t_word o_word
);

    logic [2:0] r_idx, n_idx;
    logic       final_word;

    assign final_word = (i_cmd.n == 4'd0) || ({1'b0, r_idx} == i_cmd.n - 4'd1);
    assign o_word_push = !i_cmd_empty && !i_out_full;
    assign o_cmd_pop   = o_word_push && final_word;

    always_comb begin
        o_word.has_byte     = (i_cmd.n != 4'd0);
        o_word.out_byte     = o_word.has_byte ? i_cmd.data[{r_idx, 3'b000} +: 8] : 8'd0;
        o_word.out_last     = i_cmd.last && final_word;
        o_word.any_replaced = i_cmd.last && final_word && i_cmd.any_rep;
    end

    always_comb begin
        n_idx = r_idx;
        if (o_word_push) begin
            n_idx = final_word ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

>>> src/stream_pattern_replace_unit.sv
// streaming find-and-replace top level: front end, job queue, back end, result queue
// depends on spr_pkg, spr_front, spr_fifo, spr_back and assert_macros.svh
//
// usage:
//   input words (i_in_byte, i_in_last) are taken at an edge with push high and full low.
//   results (o_out_byte, o_has_byte, o_out_last, o_any_replaced) are shown while
//   empty is low and leave at an edge with pop high.
//   config is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data); write only
//   while idle. writing the pattern length drops any pending window bytes.
// timing:
//   the front end compares the window against the pattern in the cycle a word is
//   taken and queues at most one job; the back end turns a job into 1 to 8 result
//   words, one per cycle while the result queue has room. input runs at one word
//   per cycle while jobs expand to at most one result each; a job holds the back
//   end until its final result word is pushed, and the 4-entry job queue absorbs
//   bursts before full rises.
// reset and stall:
//   synchronous active-low reset empties both queues and the window and loads
//   the register defaults. when the receiver stops popping, the 2-entry result
//   queue fills, the back end halts, then the job queue fills and full rises.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stream_pattern_replace_unit
    import spr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  t_cfg_idx               i_cfg_index,
    input  logic [MAX_BYTES*8-1:0] i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_in_last,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             o_out_byte,
    output logic                   o_has_byte,
    output logic                   o_out_last,
    output logic                   o_any_replaced
);

    logic  accept;
    logic  cmd_push, cmd_empty, cmd_pop;
    t_cmd  cmd_in, cmd_head;
    logic  word_push, out_full;
    t_word word_in, word_head;

    assign accept = push && !full;

    spr_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .i_last      (i_in_last),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    spr_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (4)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    spr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_word_push (word_push),
        .o_word      (word_in)
    );

    spr_fifo #(
        .WIDTH ($bits(t_word)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (word_push),
        .i_data  (word_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (word_head),
        .o_empty (empty)
    );

    assign o_out_byte     = word_head.out_byte;
    assign o_has_byte     = word_head.has_byte;
    assign o_out_last     = word_head.out_last;
    assign o_any_replaced = word_head.any_replaced;

    // end marker and replace flag only ever ride on the final word
    `SPR_ASSERT(a_marker_is_last, i_clk, i_rst_n, (!empty && !o_has_byte) |-> o_out_last, "empty marker without last")
    `SPR_ASSERT(a_flag_on_last, i_clk, i_rst_n, (!empty && o_any_replaced) |-> o_out_last, "replace flag before last word")
    `SPR_ASSERT(a_marker_zero, i_clk, i_rst_n, (!empty && !o_has_byte) |-> (o_out_byte == 8'd0), "end marker carries data")
    // a job is only retired together with its final result word
    `SPR_ASSERT(a_job_retire, i_clk, i_rst_n, cmd_pop |-> (word_push && (word_in.out_last == cmd_head.last)), "job retired without word")
    `SPR_ASSERT_ALWAYS(a_reset_empty, i_clk, $rose(i_rst_n) |-> (empty && !full), "queues not empty after reset")

endmodule

>>> tb/sv/spr_replace_checker.sv
// checker for the find-and-replace block: watches config, input and result channels,
// predicts the result words of every accepted input word and compares them in order
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_replace_checker
    import spr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  t_cfg_idx               i_cfg_index,
    input  logic [MAX_BYTES*8-1:0] i_cfg_data,
    input  logic                   push,
    input  logic                   full,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_in_last,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [7:0]             i_out_byte,
    input  logic                   i_has_byte,
    input  logic                   i_out_last,
    input  logic                   i_any_replaced,
    output int                     o_fail_count,
    output int                     o_pending
);

    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] rep_bytes;
    logic [3:0]  rep_len;
    logic        ign_case;
    logic [7:0]  win [8];
    int          win_cnt;
    logic        seen_rep;
    t_word       out_words_due[$];

    function automatic logic [7:0] case_fold(input logic [7:0] c);
        if (ign_case && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic t_word data_word(input logic [7:0] b);
        t_word w;
        w.out_byte     = b;
        w.has_byte     = 1'b1;
        w.out_last     = 1'b0;
        w.any_replaced = 1'b0;
        return w;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic predict_replace(input logic [7:0] b, input logic l);
        int   plen;
        int   rlen;
        int   i;
        int   base;
        logic hit;
        t_word w;
        plen = (pat_len == 4'd0) ? 1 : ((pat_len > 4'd8) ? 8 : int'(pat_len));
        rlen = (rep_len > 4'd8) ? 8 : int'(rep_len);
        base = out_words_due.size();
        win[win_cnt & 7] = b;
        win_cnt++;
        if (win_cnt >= plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++) begin
                if (case_fold(win[i]) != case_fold(pat_bytes[8*i +: 8])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                for (i = 0; i < rlen; i++) begin
                    out_words_due.push_back(data_word(rep_bytes[8*i +: 8]));
                end
                win_cnt  = 0;
                seen_rep = 1'b1;
            end else begin
                out_words_due.push_back(data_word(win[0]));
                for (i = 1; i < win_cnt; i++) begin
                    win[i-1] = win[i];
                end
                win_cnt--;
            end
        end
        if (l) begin
            for (i = 0; i < win_cnt; i++) begin
                out_words_due.push_back(data_word(win[i]));
            end
            win_cnt = 0;
            if (out_words_due.size() == base) begin
                // nothing left to emit: bare end marker
                w = data_word(8'h00);
                w.has_byte = 1'b0;
                out_words_due.push_back(w);
            end
            w = out_words_due.pop_back();
            w.out_last     = 1'b1;
            w.any_replaced = seen_rep;
            out_words_due.push_back(w);
            seen_rep = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            pat_bytes = '0;
            pat_len   = 4'd1;
            rep_bytes = '0;
            rep_len   = 4'd0;
            ign_case  = 1'b0;
            win_cnt   = 0;
            seen_rep  = 1'b0;
            out_words_due.delete();
        end else begin
            if (!empty && pop) begin
                if (out_words_due.size() == 0) begin
                    $error("result word %0h with nothing expected", i_out_byte);
                    o_fail_count++;
                end else begin
                    w = out_words_due.pop_front();
                    check_field("out_byte", w.out_byte, i_out_byte);
                    check_field("has_byte", w.has_byte, i_has_byte);
                    check_field("out_last", w.out_last, i_out_last);
                    check_field("any_replaced", w.any_replaced, i_any_replaced);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_PAT_BYTES: pat_bytes = i_cfg_data;
                    REG_PAT_LEN: begin
                        pat_len = i_cfg_data[3:0];
                        win_cnt = 0;
                    end
                    REG_REP_BYTES: rep_bytes = i_cfg_data;
                    REG_REP_LEN: rep_len = i_cfg_data[3:0];
                    REG_IGN_CASE: ign_case = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                predict_replace(i_in_byte, i_in_last);
            end
        end
        o_pending = out_words_due.size();
    end

endmodule

>>> tb/sv/tb.sv
// testbench top for stream_pattern_replace_unit: drives config, strings and pop timing,
// and gives the verdict from the checker's failure count and pending count
// depends on spr_pkg, stream_pattern_replace_unit and spr_replace_checker
`timescale 1ns / 1ps

module tb;
    import spr_pkg::*;

    typedef logic [7:0] t_bytes[$];

    localparam t_cfg_idx REG_NONE = 3'd7;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 18;
    localparam int STALL_PHASE   = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int SETTLE_CYCLES = 12;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    t_cfg_idx               i_cfg_index;
    logic [MAX_BYTES*8-1:0] i_cfg_data;
    logic                   push;
    logic                   full;
    logic [7:0]             i_in_byte;
    logic                   i_in_last;
    logic                   empty;
    logic                   pop;
    logic [7:0]             o_out_byte;
    logic                   o_has_byte;
    logic                   o_out_last;
    logic                   o_any_replaced;

    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_requests;
    int          words_sent;
    int          phase;
    int          target;
    logic [63:0] cur_pat;
    int          cur_len;
    t_bytes      str;

    stream_pattern_replace_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_has_byte     (o_has_byte),
        .o_out_last     (o_out_last),
        .o_any_replaced (o_any_replaced)
    );

    spr_replace_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .empty          (empty),
        .pop            (pop),
        .i_out_byte     (o_out_byte),
        .i_has_byte     (o_has_byte),
        .i_out_last     (o_out_last),
        .i_any_replaced (o_any_replaced),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random pops, plus a long hold-off when requested
    initial begin
        int left;
        int seen;
        left = 0;
        seen = 0;
        pop  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != seen) begin
                seen = hold_requests;
                left = HOLD_CYCLES;
            end
            if (left > 0) begin
                pop <= 1'b0;
                left--;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [7:0] letter_byte();
        case ($urandom_range(0, 4))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h41;
            3: return 8'h42;
            default: return 8'h00;
        endcase
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_PAT_BYTES) begin
            cur_pat = val;
        end
        if (idx == REG_PAT_LEN) begin
            cur_len = (val[3:0] == 4'd0) ? 1 : ((val[3:0] > 4'd8) ? 8 : int'(val[3:0]));
        end
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic send_bytes(input t_bytes s, input bit with_last);
        int k;
        for (k = 0; k < s.size(); k++) begin
            send_word(s[k], with_last && (k == s.size() - 1));
        end
    endtask

    // mostly pattern copies and prefixes with random case, some pure noise strings
    task automatic send_random_string(input bit with_last);
        t_bytes     s;
        int         want;
        int         cut;
        int         j;
        bit         noise;
        logic [7:0] c;
        want  = $urandom_range(1, 14);
        noise = ($urandom_range(0, 99) < 15);
        while (s.size() < want) begin
            if (noise) begin
                s.push_back(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 3))
                    0, 1: cut = cur_len;
                    2: cut = $urandom_range(1, cur_len);
                    default: cut = 0;
                endcase
                for (j = 0; j < cut; j++) begin
                    c = cur_pat[8*j +: 8];
                    if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1)) begin
                        c = c ^ 8'h20;
                    end
                    s.push_back(c);
                end
                if (cut == 0) begin
                    s.push_back($urandom_range(0, 1) ? letter_byte() : 8'($urandom_range(0, 255)));
                end
            end
        end
        send_bytes(s, with_last);
    endtask

    task automatic cfg_random();
        logic [63:0] p;
        int          plen;
        int          j;
        p = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            for (j = 0; j < 8; j++) begin
                p[8*j +: 8] = letter_byte();
            end
        end
        case ($urandom_range(0, 9))
            0: plen = $urandom_range(9, 15);
            1: plen = 0;
            2: plen = 8;
            default: plen = $urandom_range(1, 4);
        endcase
        if ($urandom_range(0, 3) != 0) cfg_write(REG_PAT_BYTES, p);
        if ($urandom_range(0, 3) != 0) cfg_write(REG_PAT_LEN, 64'(plen));
        if ($urandom_range(0, 3) != 0) cfg_write(REG_REP_BYTES, {$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) cfg_write(REG_REP_LEN, 64'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) != 0) cfg_write(REG_IGN_CASE, 64'($urandom_range(0, 1)));
        if ($urandom_range(0, 5) == 0) begin
            cfg_write(t_cfg_idx'($urandom_range(REG_IGN_CASE + 1, REG_NONE)), {$urandom, $urandom});
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        int guard;
        push  <= 1'b0;
        guard = 0;
        @(posedge i_clk);
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = REG_PAT_BYTES;
        i_cfg_data     = '0;
        push           = 1'b0;
        i_in_byte      = 8'h00;
        i_in_last      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        words_sent     = 0;
        cur_pat        = '0;
        cur_len        = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: zero pattern byte replaced by nothing gives a bare end marker
        str = {8'h00};
        send_bytes(str, 1'b1);
        str = {8'hFF};
        send_bytes(str, 1'b1);
        wait_idle();

        // longest pattern and longest replacement
        cfg_write(REG_PAT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_PAT_LEN, 64'd8);
        cfg_write(REG_REP_BYTES, 64'h0123_4567_89AB_CDEF);
        cfg_write(REG_REP_LEN, 64'd8);
        i_cfg_wr_en <= 1'b0;
        str = {};
        repeat (8) str.push_back(8'hFF);
        send_bytes(str, 1'b1);
        wait_idle();

        // zero pattern length acts as one, oversized replacement length saturates
        cfg_write(REG_PAT_BYTES, 64'h41);
        cfg_write(REG_PAT_LEN, 64'd0);
        cfg_write(REG_REP_LEN, 64'd15);
        cfg_write(REG_IGN_CASE, 64'd1);
        i_cfg_wr_en <= 1'b0;
        str = {8'h61, 8'h42};
        send_bytes(str, 1'b1);
        wait_idle();

        // oversized pattern length saturates, unused index is ignored
        cfg_write(REG_PAT_LEN, 64'd15);
        cfg_write(REG_REP_LEN, 64'd0);
        cfg_write(REG_IGN_CASE, 64'd0);
        cfg_write(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        i_cfg_wr_en <= 1'b0;
        str = {8'h10, 8'h20, 8'h30};
        send_bytes(str, 1'b1);
        wait_idle();

        // case folding on, then off
        cfg_write(REG_PAT_BYTES, 64'h7A5A);
        cfg_write(REG_PAT_LEN, 64'd2);
        cfg_write(REG_IGN_CASE, 64'd1);
        i_cfg_wr_en <= 1'b0;
        str = {8'h7A, 8'h5A};
        send_bytes(str, 1'b1);
        wait_idle();
        cfg_write(REG_IGN_CASE, 64'd0);
        i_cfg_wr_en <= 1'b0;
        send_bytes(str, 1'b1);
        wait_idle();

        // pattern length written mid-string drops the pending window
        cfg_write(REG_PAT_LEN, 64'd4);
        i_cfg_wr_en <= 1'b0;
        send_word(8'h5A, 1'b0);
        wait_idle();
        cfg_write(REG_PAT_LEN, 64'd1);
        i_cfg_wr_en <= 1'b0;
        send_word(8'h7A, 1'b1);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            cfg_random();
            if (phase == STALL_PHASE) begin
                hold_requests++;
            end
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                send_random_string(1'b1);
            end
            if ($urandom_range(0, 2) == 0) begin
                send_random_string(1'b0);
            end
            wait_idle();
        end

        if (pending != 0) begin
            $error("%0d result words never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
